// ----- hdl/shs_pkg.sv -----
// shs_pkg: types, codes and constants shared by the slider height solver
// used by shs_front, shs_fifo, shs_back and slider_height_solver_core

package shs_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned ArmW     = 15;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned DiffSqW  = 2 * CoordW + 1;
  localparam int unsigned ArmSqW   = 2 * ArmW;
  localparam int unsigned ZsqW     = DiffSqW + 2;
  localparam int unsigned RadW     = ArmSqW;
  localparam int unsigned RootW    = RadW / 2;
  localparam int unsigned CandW    = CoordW + 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);

  localparam logic [ArmW-1:0]   ArmLengthRst = 15'd2048;
  localparam logic [CoordW-1:0] MaxHeightRst = 16'd3840;
  localparam logic [CoordW-1:0] MinHeightRst = 16'd0;

  localparam logic [RadW-1:0] RootBitInit = RadW'(1) << (RadW - 2);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARM_LENGTH = 2'd0,
    CFG_MAX_HEIGHT = 2'd1,
    CFG_MIN_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_REACH = 2'd1,
    ST_LIMIT    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROOT,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] max_height;
    logic signed [CoordW-1:0] min_height;
  } limits_t;

  typedef struct packed {
    logic [CoordW-1:0] base_x;
    logic [CoordW-1:0] base_y;
    logic [CoordW-1:0] table_z;
    logic              last;
    logic              reach;
    logic [RadW-1:0]   radicand;
  } job_t;

endpackage

// ----- hdl/shs_front.sv -----
// shs_front: accepts one slider item, squares the offsets and classifies reach
// depends on shs_pkg; feeds shs_fifo

module shs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [shs_pkg::CoordW-1:0]      table_x_i,
  input  logic [shs_pkg::CoordW-1:0]      table_y_i,
  input  logic [shs_pkg::CoordW-1:0]      table_z_i,
  input  logic [shs_pkg::CoordW-1:0]      base_x_i,
  input  logic [shs_pkg::CoordW-1:0]      base_y_i,
  input  logic                            last_slider_i,
  input  logic [shs_pkg::ArmW-1:0]        arm_length_i,
  output logic                            job_push_o,
  input  logic                            job_full_i,
  output shs_pkg::job_t                   job_o
);

  logic                                valid_q;
  logic                                accept;
  logic signed [shs_pkg::DiffW-1:0]    dx, dy;
  logic signed [2*shs_pkg::DiffW-1:0]  dx_sq, dy_sq;
  logic [shs_pkg::DiffSqW-1:0]         dx2_d, dx2_q, dy2_d, dy2_q;
  logic [shs_pkg::ArmSqW-1:0]          len2_d, len2_q;
  logic [shs_pkg::CoordW-1:0]          base_x_q, base_y_q, table_z_q;
  logic                                last_q;
  logic signed [shs_pkg::ZsqW-1:0]     zsq;

  assign accept = push & ~full;
  assign full   = valid_q & job_full_i;

  assign dx     = $signed({base_x_i[shs_pkg::CoordW-1], base_x_i})
                - $signed({table_x_i[shs_pkg::CoordW-1], table_x_i});
  assign dy     = $signed({base_y_i[shs_pkg::CoordW-1], base_y_i})
                - $signed({table_y_i[shs_pkg::CoordW-1], table_y_i});
  assign dx_sq  = dx * dx;
  assign dy_sq  = dy * dy;
  assign dx2_d  = dx_sq[shs_pkg::DiffSqW-1:0];
  assign dy2_d  = dy_sq[shs_pkg::DiffSqW-1:0];
  assign len2_d = arm_length_i * arm_length_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (!job_full_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx2_q     <= dx2_d;
      dy2_q     <= dy2_d;
      len2_q    <= len2_d;
      base_x_q  <= base_x_i;
      base_y_q  <= base_y_i;
      table_z_q <= table_z_i;
      last_q    <= last_slider_i;
    end
  end

  // zsq = L^2 - dx^2 - dy^2, exact
  assign zsq = $signed({{(shs_pkg::ZsqW-shs_pkg::ArmSqW){1'b0}}, len2_q})
             - $signed({2'b00, dx2_q})
             - $signed({2'b00, dy2_q});

  assign job_push_o     = valid_q;
  assign job_o.base_x   = base_x_q;
  assign job_o.base_y   = base_y_q;
  assign job_o.table_z  = table_z_q;
  assign job_o.last     = last_q;
  assign job_o.reach    = ~zsq[shs_pkg::ZsqW-1] & (|zsq);
  assign job_o.radicand = zsq[shs_pkg::RadW-1:0];

endmodule

// ----- hdl/shs_fifo.sv -----
// shs_fifo: short job queue between front and back
// depends on shs_pkg

module shs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  shs_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output shs_pkg::job_t data_o
);

  shs_pkg::job_t                 mem_q [shs_pkg::FifoDepth];
  logic [shs_pkg::FifoAw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [shs_pkg::FifoCntW-1:0]  cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == shs_pkg::FifoCntW'(shs_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == shs_pkg::FifoAw'(shs_pkg::FifoDepth - 1))
                  ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == shs_pkg::FifoAw'(shs_pkg::FifoDepth - 1))
                  ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= shs_pkg::FifoCntW'(shs_pkg::FifoDepth))
    else $error("job queue count beyond depth");

endmodule

// ----- hdl/shs_back.sv -----
// shs_back: digit-by-digit root, limit check, set tracking and result register
// depends on shs_pkg; fed by shs_fifo

module shs_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_empty_i,
  output logic                            job_pop_o,
  input  shs_pkg::job_t                   job_i,
  input  shs_pkg::limits_t                limits_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [shs_pkg::CoordW-1:0]      slider_x_o,
  output logic [shs_pkg::CoordW-1:0]      slider_y_o,
  output logic [shs_pkg::CoordW-1:0]      slider_hgt_o,
  output logic [1:0]                      status_o,
  output logic                            set_done_o,
  output logic                            set_feasible_o
);

  shs_pkg::back_state_e             state_q, state_d;
  shs_pkg::job_t                    job_q;
  logic [shs_pkg::RadW-1:0]         root_q, root_d, rem_q, rem_d, bit_q, bit_d;
  logic [shs_pkg::RadW:0]           trial;
  logic                             load_job, out_load;
  logic signed [shs_pkg::CandW-1:0] cand, max_ext, min_ext;
  shs_pkg::status_e                 status;
  logic                             acc;
  logic                             all_ok_q;
  logic                             out_valid_q;
  logic [shs_pkg::CoordW-1:0]       out_x_q, out_y_q, out_z_q;
  shs_pkg::status_e                 out_status_q;
  logic                             out_done_q, out_feas_q;

  assign trial = {1'b0, root_q} + {1'b0, bit_q};

  assign cand    = $signed({{2{job_q.table_z[shs_pkg::CoordW-1]}}, job_q.table_z})
                 + $signed({{(shs_pkg::CandW-shs_pkg::RootW){1'b0}},
                            root_q[shs_pkg::RootW-1:0]});
  assign max_ext = shs_pkg::CandW'(limits_i.max_height);
  assign min_ext = shs_pkg::CandW'(limits_i.min_height);

  always_comb begin
    if (!job_q.reach) begin
      status = shs_pkg::ST_NO_REACH;
    end else if (cand < max_ext && cand > min_ext) begin
      status = shs_pkg::ST_OK;
    end else begin
      status = shs_pkg::ST_LIMIT;
    end
  end

  assign acc = all_ok_q & (status == shs_pkg::ST_OK);

  always_comb begin
    state_d  = state_q;
    root_d   = root_q;
    rem_d    = rem_q;
    bit_d    = bit_q;
    load_job = 1'b0;
    out_load = 1'b0;
    case (state_q)
      shs_pkg::B_IDLE: begin
        if (!job_empty_i) begin
          load_job = 1'b1;
          root_d   = '0;
          rem_d    = job_i.radicand;
          bit_d    = shs_pkg::RootBitInit;
          state_d  = job_i.reach ? shs_pkg::B_ROOT : shs_pkg::B_DONE;
        end
      end
      shs_pkg::B_ROOT: begin
        if ({1'b0, rem_q} >= trial) begin
          rem_d  = rem_q - trial[shs_pkg::RadW-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = shs_pkg::B_DONE;
        end
      end
      shs_pkg::B_DONE: begin
        if (!out_valid_q || pop) begin
          out_load = 1'b1;
          state_d  = shs_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = shs_pkg::B_IDLE;
      end
    endcase
  end

  assign job_pop_o = load_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shs_pkg::B_IDLE;
      all_ok_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        all_ok_q    <= job_q.last ? 1'b1 : acc;
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    if (load_job) begin
      job_q <= job_i;
    end
    if (out_load) begin
      out_x_q      <= job_q.base_x;
      out_y_q      <= job_q.base_y;
      out_z_q      <= (status == shs_pkg::ST_OK) ? cand[shs_pkg::CoordW-1:0] : '0;
      out_status_q <= status;
      out_done_q   <= job_q.last;
      out_feas_q   <= job_q.last & acc;
    end
  end

  assign empty          = ~out_valid_q;
  assign slider_x_o     = out_x_q;
  assign slider_y_o     = out_y_q;
  assign slider_hgt_o   = out_z_q;
  assign status_o       = out_status_q;
  assign set_done_o     = out_done_q;
  assign set_feasible_o = out_feas_q;

  a_root_bit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == shs_pkg::B_ROOT |-> $onehot(bit_q))
    else $error("root trial bit not one-hot");

  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == shs_pkg::B_DONE && job_q.reach |-> root_q[shs_pkg::RadW-1:shs_pkg::RootW] == '0)
    else $error("root wider than expected");

  a_feas_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_feas_q |-> out_done_q && out_status_q == shs_pkg::ST_OK)
    else $error("set feasible without ok set end");

endmodule

// ----- hdl/slider_height_solver_core.sv -----
// slider_height_solver_core: top level of the linear delta slider height solver
// depends on shs_pkg, shs_front, shs_fifo, shs_back
//
// Usage:
//   Input channel is queue-like: an item transfers on a rising edge with push
//   high and full low. Each item is one slider: table vertex (x,y,z), base
//   (x,y) and a last-of-set flag. Results are queue-like too: while empty is
//   low the oldest result is on the result ports, and it transfers on a
//   rising edge with pop high. Exactly one result per item, in order.
//   Config: cfg_we_i writes register cfg_idx_i (0 arm length, 1 max height,
//   2 min height) with cfg_data_i; other indexes are ignored.
//   Write config only while no item is in flight.
// Datapath:
//   The front squares the offsets and registers the job, then hands it to a
//   two-entry queue. The back runs a digit-by-digit root, one digit per cycle,
//   then a check and result state; an unreachable slider skips the root loop.
//   The back takes one job at a time, while the front and queue accept new
//   items, so the root loop sets the sustained rate.
// Reset and stall:
//   Reset empties the queue and result register, restores default registers
//   and starts a new set. When the receiver stalls, the result waits in its
//   register, the back holds, the queue fills and then full goes high.

module slider_height_solver_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [shs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [shs_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [shs_pkg::CoordW-1:0]      table_x_i,
  input  logic [shs_pkg::CoordW-1:0]      table_y_i,
  input  logic [shs_pkg::CoordW-1:0]      table_z_i,
  input  logic [shs_pkg::CoordW-1:0]      base_x_i,
  input  logic [shs_pkg::CoordW-1:0]      base_y_i,
  input  logic                            last_slider_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [shs_pkg::CoordW-1:0]      slider_x_o,
  output logic [shs_pkg::CoordW-1:0]      slider_y_o,
  output logic [shs_pkg::CoordW-1:0]      slider_hgt_o,
  output logic [1:0]                      status_o,
  output logic                            set_done_o,
  output logic                            set_feasible_o
);

  logic [shs_pkg::ArmW-1:0]   arm_length_q;
  shs_pkg::limits_t           limits_q;
  logic                       job_push, job_full, job_pop, job_empty;
  shs_pkg::job_t              job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_length_q        <= shs_pkg::ArmLengthRst;
      limits_q.max_height <= shs_pkg::MaxHeightRst;
      limits_q.min_height <= shs_pkg::MinHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        shs_pkg::CFG_ARM_LENGTH: arm_length_q <= cfg_data_i[shs_pkg::ArmW-1:0];
        shs_pkg::CFG_MAX_HEIGHT: limits_q.max_height <= cfg_data_i;
        shs_pkg::CFG_MIN_HEIGHT: limits_q.min_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  shs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .table_x_i     (table_x_i),
    .table_y_i     (table_y_i),
    .table_z_i     (table_z_i),
    .base_x_i      (base_x_i),
    .base_y_i      (base_y_i),
    .last_slider_i (last_slider_i),
    .arm_length_i  (arm_length_q),
    .job_push_o    (job_push),
    .job_full_i    (job_full),
    .job_o         (job_in)
  );

  shs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .full_o  (job_full),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  shs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_empty_i    (job_empty),
    .job_pop_o      (job_pop),
    .job_i          (job_out),
    .limits_i       (limits_q),
    .empty          (empty),
    .pop            (pop),
    .slider_x_o     (slider_x_o),
    .slider_y_o     (slider_y_o),
    .slider_hgt_o   (slider_hgt_o),
    .status_o       (status_o),
    .set_done_o     (set_done_o),
    .set_feasible_o (set_feasible_o)
  );

endmodule

// ----- sim/tb_slider_height_solver_core.sv -----
// tb_slider_height_solver_core: self-checking testbench for the slider height solver
// predicts each slider result in order and compares it field by field with the output queue
// depends on shs_pkg and slider_height_solver_core
`timescale 1ns / 100ps

module tb_slider_height_solver_core;
  import shs_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
  localparam int DrainCycles = 24;
  localparam int HoldCycles  = 400;

  typedef struct packed {
    logic signed [CoordW-1:0] table_x;
    logic signed [CoordW-1:0] table_y;
    logic signed [CoordW-1:0] table_z;
    logic signed [CoordW-1:0] base_x;
    logic signed [CoordW-1:0] base_y;
    logic                     last;
  } slider_item_t;

  typedef struct packed {
    logic [CoordW-1:0] slider_x;
    logic [CoordW-1:0] slider_y;
    logic [CoordW-1:0] slider_hgt;
    status_e           status;
    logic              set_done;
    logic              set_feasible;
  } slider_result_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                push       = 1'b0;
  logic                pop        = 1'b0;
  logic                hold_kick  = 1'b0;
  slider_item_t        drv_item   = '0;
  logic                full;
  logic                empty;
  logic [CoordW-1:0]   slider_x_o;
  logic [CoordW-1:0]   slider_y_o;
  logic [CoordW-1:0]   slider_hgt_o;
  logic [1:0]          status_o;
  logic                set_done_o;
  logic                set_feasible_o;

  // shadow copy of the block state
  logic [ArmW-1:0]          arm_cfg = ArmLengthRst;
  logic signed [CoordW-1:0] max_cfg = MaxHeightRst;
  logic signed [CoordW-1:0] min_cfg = MinHeightRst;
  bit                       set_ok_q = 1'b1;

  slider_item_t   pose_items_q[$];
  slider_result_t solved_sliders_q[$];

  bit             no_idle = 1'b0;
  int             tx_gap;
  int             rx_gap;
  int             hold_left;
  int             mismatches;
  int             items_sent;
  int             results_seen;
  int             n_ok;
  int             n_no_reach;
  int             n_limit;
  int             n_sets;
  slider_result_t want;
  slider_result_t got;

  slider_height_solver_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .table_x_i      (drv_item.table_x),
    .table_y_i      (drv_item.table_y),
    .table_z_i      (drv_item.table_z),
    .base_x_i       (drv_item.base_x),
    .base_y_i       (drv_item.base_y),
    .last_slider_i  (drv_item.last),
    .empty          (empty),
    .pop            (pop),
    .slider_x_o     (slider_x_o),
    .slider_y_o     (slider_y_o),
    .slider_hgt_o   (slider_hgt_o),
    .status_o       (status_o),
    .set_done_o     (set_done_o),
    .set_feasible_o (set_feasible_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 32;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // expected result of one slider, advances the running set flag
  function automatic slider_result_t solve_slider_height(input slider_item_t it);
    slider_result_t r;
    longint         dx;
    longint         dy;
    longint         len;
    longint         zsq;
    longint         cand;
    bit             acc;
    r          = '0;
    r.slider_x = it.base_x;
    r.slider_y = it.base_y;
    dx  = longint'(it.base_x) - longint'(it.table_x);
    dy  = longint'(it.base_y) - longint'(it.table_y);
    len = longint'(arm_cfg);
    zsq = len * len - dx * dx - dy * dy;
    if (zsq > 0) begin
      cand = longint'(it.table_z) + longint'(floor_root(longint'(zsq)));
      if (cand < longint'(max_cfg) && cand > longint'(min_cfg)) begin
        r.status     = ST_OK;
        r.slider_hgt = cand[CoordW-1:0];
      end else begin
        r.status = ST_LIMIT;
      end
    end else begin
      r.status = ST_NO_REACH;
    end
    acc            = set_ok_q && (r.status == ST_OK);
    r.set_done     = it.last;
    r.set_feasible = it.last && acc;
    set_ok_q       = it.last ? 1'b1 : acc;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender: one transfer per edge at most, gaps chosen after each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      tx_gap = 0;
    end else begin
      if (push && !full) begin
        solved_sliders_q.push_back(solve_slider_height(drv_item));
        items_sent++;
        tx_gap = pick_gap();
      end
      if (!(push && full)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (pose_items_q.size() != 0) begin
          drv_item <= pose_items_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      rx_gap = 0;
    end else begin
      if (pop && !empty) begin
        got = '{slider_x_o, slider_y_o, slider_hgt_o, status_e'(status_o),
                set_done_o, set_feasible_o};
        results_seen++;
        if (solved_sliders_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: x=%h y=%h z=%h st=%0d done=%b feas=%b",
                     $realtime, got.slider_x, got.slider_y, got.slider_hgt, got.status,
                     got.set_done, got.set_feasible);
        end else begin
          want = solved_sliders_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp x=%h y=%h z=%h st=%0d done=%b feas=%b",
                        " got x=%h y=%h z=%h st=%0d done=%b feas=%b"},
                       $realtime, want.slider_x, want.slider_y, want.slider_hgt, want.status,
                       want.set_done, want.set_feasible, got.slider_x, got.slider_y,
                       got.slider_hgt, status_o, got.set_done, got.set_feasible);
          end
        end
        case (status_o)
          ST_OK:       n_ok++;
          ST_NO_REACH: n_no_reach++;
          default:     n_limit++;
        endcase
        if (set_done_o) n_sets++;
        rx_gap = pick_gap();
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ARM_LENGTH: arm_cfg = val[ArmW-1:0];
      CFG_MAX_HEIGHT: max_cfg = val;
      CFG_MIN_HEIGHT: min_cfg = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input int arm, input int hi, input int lo);
    set_reg(CFG_ARM_LENGTH, CfgDataW'(arm));
    set_reg(CFG_MAX_HEIGHT, CfgDataW'(hi));
    set_reg(CFG_MIN_HEIGHT, CfgDataW'(lo));
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pose_items_q.size() != 0 || push || solved_sliders_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic add_item(input int tx, input int ty, input int tz,
                          input int bx, input int by, input bit last);
    pose_items_q.push_back('{16'(tx), 16'(ty), 16'(tz), 16'(bx), 16'(by), last});
  endtask

  // slider of a plausible pose: table near the base, height around the limits
  function automatic slider_item_t pose_slider(input bit last);
    slider_item_t it;
    int reach;
    int bx;
    int by;
    int ox;
    int oy;
    int lo;
    int hi;
    reach = int'(arm_cfg) + 64;
    if (reach > 24000) reach = 24000;
    bx = int'($urandom_range(0, 16000)) - 8000;
    by = int'($urandom_range(0, 16000)) - 8000;
    ox = int'($urandom_range(0, 2 * reach)) - reach;
    oy = int'($urandom_range(0, 2 * reach)) - reach;
    lo = int'(min_cfg) - int'(arm_cfg) - 256;
    hi = int'(max_cfg) + 256;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    if (hi < lo) hi = lo;
    it.base_x  = 16'(bx);
    it.base_y  = 16'(by);
    it.table_x = 16'(bx - ox);
    it.table_y = 16'(by - oy);
    it.table_z = 16'(lo + int'($urandom_range(0, hi - lo)));
    it.last    = last;
    return it;
  endfunction

  function automatic slider_item_t noise_slider();
    slider_item_t it;
    it.table_x = 16'($urandom());
    it.table_y = 16'($urandom());
    it.table_z = 16'($urandom());
    it.base_x  = 16'($urandom());
    it.base_y  = 16'($urandom());
    it.last    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // mostly whole pose sets, some loose noise that also breaks sets
  task automatic run_random(input int n_items);
    int made;
    int set_len;
    int k;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        set_len = $urandom_range(1, 8);
        for (k = 0; k < set_len; k++) pose_items_q.push_back(pose_slider(k == set_len - 1));
        made += set_len;
      end else begin
        pose_items_q.push_back(noise_slider());
        made++;
      end
    end
    wait_drained();
  endtask

  initial begin
    int lo;
    int hi;
    int k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default registers: reach, tangent, both limits exactly, set flags
    add_item(0, 0, 0, 0, 0, 1'b0);
    add_item(0, 0, 0, 2048, 0, 1'b0);
    add_item(0, 0, 0, 2047, 0, 1'b0);
    add_item(0, 0, 1792, 0, 0, 1'b0);
    add_item(0, 0, 1791, 0, 0, 1'b0);
    add_item(0, 0, -2048, 0, 0, 1'b0);
    add_item(0, 0, -2047, 0, 0, 1'b1);
    add_item(100, -100, 0, 100, -100, 1'b0);
    add_item(-500, 300, 100, -400, 200, 1'b0);
    add_item(0, 0, 500, 0, 0, 1'b1);
    add_item(-32768, -32768, -32768, 32767, 32767, 1'b1);
    add_item(32767, 32767, 32767, -32768, -32768, 1'b0);
    add_item(32767, 32767, 32767, 32767, 32767, 1'b0);
    add_item(-32768, -32768, -32768, -32768, -32768, 1'b1);
    add_item(0, 0, 1000, 0, 0, 1'b1);
    add_item(1448, 1448, 0, 0, 0, 1'b0);
    add_item(1449, 1448, 0, 0, 0, 1'b1);
    wait_drained();
    run_random(200);

    // unused index is ignored, zero arm never reaches
    set_reg(CfgIdxUnused, 16'h5a5a);
    set_limits(0, 32767, -32768);
    add_item(0, 0, 0, 0, 0, 1'b1);
    add_item(1, 0, 0, 0, 0, 1'b1);
    wait_drained();
    run_random(100);

    // widest arm, upper bit of the data word set
    set_reg(CFG_ARM_LENGTH, 16'hffff);
    add_item(0, 0, -32768, 0, 0, 1'b0);
    add_item(0, 0, 1, 0, 0, 1'b0);
    add_item(-16384, -16384, 0, 16383, 16383, 1'b1);
    wait_drained();
    run_random(250);

    // crossed and equal limits
    set_limits(2048, -100, 100);
    run_random(150);
    set_limits(2048, 500, 500);
    run_random(50);

    // no idling, receiver holds off while the sender keeps offering
    set_limits(3000, 6000, -1000);
    no_idle = 1'b1;
    for (k = 0; k < 250; k++) pose_items_q.push_back(pose_slider(k % 6 == 5));
    @(posedge clk_i);
    hold_kick <= 1'b1;
    @(posedge clk_i);
    hold_kick <= 1'b0;
    wait_drained();
    no_idle = 1'b0;

    // random registers
    for (k = 0; k < 4; k++) begin
      lo = int'($urandom_range(0, 40000)) - 20000;
      hi = lo + int'($urandom_range(1, 12000));
      if (hi > 32767) hi = 32767;
      set_limits($urandom_range(0, 32767), hi, lo);
      no_idle = (k == 2);
      run_random(150);
    end
    no_idle = 1'b0;
    set_limits(ArmLengthRst, MaxHeightRst, MinHeightRst);
    run_random(50);

    $display("sent %0d sliders, checked %0d results in %0d completed sets", items_sent,
             results_seen, n_sets);
    $display("status mix: %0d ok, %0d unreachable, %0d out of limits", n_ok, n_no_reach,
             n_limit);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results still expected", solved_sliders_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
